// ===== hw/rtl/rvc_pkg.sv =====
package rvc_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_RST1, S_RST2, S_MRD, S_DEC, S_EXE, S_MD, S_ST, S_LDX, S_WB, S_DONE
  } state_t;

  typedef enum logic [1:0] {EX_WB, EX_MD, EX_LD, EX_ST} ex_path_t;

  typedef enum logic [1:0] {MD_MUL, MD_MULH, MD_DIV, MD_REM} md_op_t;

  typedef enum logic [1:0] {MDS_IDLE, MDS_RUN, MDS_FIN} md_state_t;

  typedef struct packed {
    logic   start;
    md_op_t kind;
  } md_req_t;

  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_END    = 2'd1;
  localparam logic [1:0] CFG_STACK  = 2'd2;
  localparam logic [1:0] CFG_GLOBAL = 2'd3;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPW    = 7'h3B;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMMW = 7'h1B;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [9:0] FK_ADD  = 10'h000;
  localparam logic [9:0] FK_SUB  = 10'h100;
  localparam logic [9:0] FK_MUL  = 10'h008;
  localparam logic [9:0] FK_SLL  = 10'h001;
  localparam logic [9:0] FK_MULH = 10'h009;
  localparam logic [9:0] FK_SLT  = 10'h002;
  localparam logic [9:0] FK_XOR  = 10'h004;
  localparam logic [9:0] FK_DIV  = 10'h00C;
  localparam logic [9:0] FK_SRL  = 10'h005;
  localparam logic [9:0] FK_SRA  = 10'h105;
  localparam logic [9:0] FK_OR   = 10'h006;
  localparam logic [9:0] FK_REM  = 10'h00E;
  localparam logic [9:0] FK_AND  = 10'h007;

  localparam logic [2:0] F3_ADDI = 3'd0;
  localparam logic [2:0] F3_SLLI = 3'd1;
  localparam logic [2:0] F3_SLTI = 3'd2;
  localparam logic [2:0] F3_XORI = 3'd4;
  localparam logic [2:0] F3_SRI  = 3'd5;
  localparam logic [2:0] F3_ORI  = 3'd6;
  localparam logic [2:0] F3_ANDI = 3'd7;

  localparam logic [2:0] F3_LB = 3'd0;
  localparam logic [2:0] F3_LH = 3'd1;
  localparam logic [2:0] F3_LW = 3'd2;
  localparam logic [2:0] F3_LD = 3'd3;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  localparam logic [5:0] F6_SRL = 6'h00;
  localparam logic [5:0] F6_SRA = 6'h10;

  localparam logic [4:0] REG_SP = 5'd2;
  localparam logic [4:0] REG_GP = 5'd3;
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  localparam logic [63:0] EXIT_CODE = 64'd4;

  localparam logic [3:0] LEN_WORD   = 4'd4;
  localparam logic [3:0] LEN_DOUBLE = 4'd8;

  function automatic logic [63:0] sext32(input logic [63:0] x);
    sext32 = {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

// ===== hw/rtl/rv64im_subset_core.sv =====
// one item is worked at a time; fetch, load and store go through the single
// byte-wide memory port, and mul, mulh, div, rem use the bit-per-cycle mul/div unit
// reset (synchronous): pc, halt flag and retired counter cleared, config to its defaults,
// register file reads zero until written, memory contents undefined
module rv64im_subset_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // load_address, load_data
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  // exec_pc, instr_word, dest_index, dest_value, dest_written, call_seen,
  // call_code, call_arg, halted, illegal
  output logic [255:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import rvc_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  state_t state, state_next, ret;

  logic [15:0] start_address, end_address, stack_init, global_init;
  logic [15:0] pc;
  logic        stopped;
  logic [63:0] retired;

  logic [AW-1:0] mbase;
  logic [3:0]    mlen, iss;
  logic          cap_v;
  logic [2:0]    cap_idx;
  logic [63:0]   mbytes, sdata;

  logic [31:0] insn;
  logic        r_step, r_wr, r_dw, r_call, r_ill, r_exit, r_w;
  logic [15:0] r_pc, r_next;
  logic [31:0] r_instr;
  logic [4:0]  r_rd;
  logic [63:0] r_val, r_code, r_arg;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic [4:0]  rf_ra1, rf_ra2, rf_wa;
  logic [63:0] rf_q1, rf_q2, rf_wd;
  logic        rf_we;

  md_req_t     md_req;
  logic [63:0] md_a, md_b, md_result;
  logic        md_done;

  logic [63:0] pc_ext, la_ext;
  logic        accept, out_load;

  // decode and execute
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [63:0] immI, immS, immB, immU, immJ, a, b, ea, tj;
  logic [15:0] pc4;
  logic [63:0] ex_val;
  logic        ex_wr, ex_ill, ex_call, ex_w;
  logic [15:0] ex_next;
  ex_path_t    ex_path;
  md_op_t      ex_md;
  logic [3:0]  ex_len;

  assign pc_ext = {48'd0, pc};
  assign la_ext = {48'd0, s_tdata[15:0]};
  assign accept = s_tvalid && s_tready;
  assign s_tready = state == S_IDLE;
  assign out_load = state == S_DONE && (!m_tvalid || m_tready);

  assign opc  = insn[6:0];
  assign rd   = insn[11:7];
  assign f3   = insn[14:12];
  assign f7   = insn[31:25];
  assign immI = {{52{insn[31]}}, insn[31:20]};
  assign immS = {{52{insn[31]}}, insn[31:25], insn[11:7]};
  assign immB = {{51{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign immU = {{32{insn[31]}}, insn[31:12], 12'd0};
  assign immJ = {{43{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  assign pc4  = pc + 16'd4;
  assign a    = rf_q1;
  assign b    = rf_q2;
  assign tj   = a + immI;

  always_comb begin
    ex_val  = '0;
    ex_wr   = 1'b0;
    ex_ill  = 1'b0;
    ex_call = 1'b0;
    ex_w    = 1'b0;
    ex_next = pc4;
    ex_path = EX_WB;
    ex_md   = MD_MUL;
    ex_len  = 4'd1 << f3[1:0];
    ea      = a + immI;
    unique case (opc)
      OPC_OP: begin
        ex_wr = 1'b1;
        unique case ({f7, f3})
          FK_ADD:  ex_val = a + b;
          FK_SUB:  ex_val = a - b;
          FK_MUL:  begin ex_path = EX_MD; ex_md = MD_MUL; end
          FK_SLL:  ex_val = a << b[5:0];
          FK_MULH: begin ex_path = EX_MD; ex_md = MD_MULH; end
          FK_SLT:  ex_val = {63'd0, $signed(a) < $signed(b)};
          FK_XOR:  ex_val = a ^ b;
          FK_DIV:  begin ex_path = EX_MD; ex_md = MD_DIV; end
          FK_SRL:  ex_val = a >> b[5:0];
          FK_SRA:  ex_val = $signed(a) >>> b[5:0];
          FK_OR:   ex_val = a | b;
          FK_REM:  begin ex_path = EX_MD; ex_md = MD_REM; end
          FK_AND:  ex_val = a & b;
          default: ex_wr = 1'b0;
        endcase
      end
      OPC_OPW: begin
        ex_wr = 1'b1;
        ex_w  = 1'b1;
        unique case ({f7, f3})
          FK_ADD:  ex_val = sext32(a + b);
          FK_SUB:  ex_val = sext32(a - b);
          FK_MUL:  begin ex_path = EX_MD; ex_md = MD_MUL; end
          FK_DIV:  begin ex_path = EX_MD; ex_md = MD_DIV; end
          FK_REM:  begin ex_path = EX_MD; ex_md = MD_REM; end
          default: ex_wr = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        if (f3[2] == 1'b0) begin
          ex_wr   = 1'b1;
          ex_path = EX_LD;
        end
      end
      OPC_OPIMM: begin
        ex_wr = 1'b1;
        priority if (f3 == F3_ADDI) ex_val = a + immI;
        else if (f3 == F3_SLLI && insn[31:26] == F6_SRL) ex_val = a << insn[25:20];
        else if (f3 == F3_SLTI) ex_val = {63'd0, $signed(a) < $signed(immI)};
        else if (f3 == F3_XORI) ex_val = a ^ immI;
        else if (f3 == F3_SRI && insn[31:26] == F6_SRL) ex_val = a >> insn[25:20];
        else if (f3 == F3_SRI && insn[31:26] == F6_SRA) ex_val = $signed(a) >>> insn[25:20];
        else if (f3 == F3_ORI) ex_val = a | immI;
        else if (f3 == F3_ANDI) ex_val = a & immI;
        else ex_wr = 1'b0;
      end
      OPC_OPIMMW: begin
        if (f3 == F3_ADDI) begin
          ex_wr  = 1'b1;
          ex_val = sext32(a + immI);
        end
      end
      OPC_JALR: begin
        if (f3 == F3_ADDI) begin
          ex_wr   = 1'b1;
          ex_val  = {48'd0, pc4};
          ex_next = {tj[15:1], 1'b0};
        end
      end
      OPC_SYSTEM: begin
        ex_call = f3 == 3'd0 && insn[31:20] == 12'd0;
      end
      OPC_STORE: begin
        ea = a + immS;
        if (f3[2] == 1'b0) ex_path = EX_ST;
      end
      OPC_BRANCH: begin
        priority if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b) ||
                      (f3 == F3_BLT && $signed(a) < $signed(b)) ||
                      (f3 == F3_BGE && $signed(a) >= $signed(b))) begin
          ex_next = pc + immB[15:0];
        end else begin
          ex_next = pc4;
        end
      end
      OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc_ext + immU;
      end
      OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = immU;
      end
      OPC_JAL: begin
        ex_wr   = 1'b1;
        ex_val  = {48'd0, pc4};
        ex_next = pc + immJ[15:0];
      end
      default: ex_ill = 1'b1;
    endcase
  end

  // memory port
  assign mem_we    = state == S_ST && iss != mlen;
  assign mem_addr  = mbase + AW'(iss);
  assign mem_wdata = sdata[{iss[2:0], 3'b000} +: 8];

  rvc_mem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // register file port
  assign rf_ra1 = (mbytes[6:0] == OPC_SYSTEM) ? REG_A7 : mbytes[19:15];
  assign rf_ra2 = (mbytes[6:0] == OPC_SYSTEM) ? REG_A0 : mbytes[24:20];

  always_comb begin
    rf_we = 1'b0;
    rf_wa = rd;
    rf_wd = r_val;
    unique case (state)
      S_RST1: begin rf_we = 1'b1; rf_wa = REG_SP; rf_wd = {48'd0, stack_init}; end
      S_RST2: begin rf_we = 1'b1; rf_wa = REG_GP; rf_wd = {48'd0, global_init}; end
      S_WB:   rf_we = r_wr && rd != 5'd0;
      default: ;
    endcase
  end

  rvc_regfile u_rf (
    .clk    (clk),
    .rst    (rst),
    .raddr1 (rf_ra1),
    .raddr2 (rf_ra2),
    .rdata1 (rf_q1),
    .rdata2 (rf_q2),
    .we     (rf_we),
    .waddr  (rf_wa),
    .wdata  (rf_wd)
  );

  assign md_req.start = state == S_EXE && ex_path == EX_MD;
  assign md_req.kind  = ex_md;
  assign md_a = ex_w ? sext32(a) : a;
  assign md_b = ex_w ? sext32(b) : b;

  rvc_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (md_a),
    .b      (md_b),
    .done   (md_done),
    .result (md_result)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            OP_LOAD:    state_next = S_ST;
            OP_RESTART: state_next = S_RST1;
            OP_STEP:    state_next = (stopped || pc == end_address) ? S_DONE : S_MRD;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_RST1: state_next = S_RST2;
      S_RST2: state_next = S_DONE;
      S_MRD:  if (iss == mlen && !cap_v) state_next = ret;
      S_ST:   if (iss == mlen) state_next = ret;
      S_DEC:  state_next = S_EXE;
      S_EXE: begin
        unique case (ex_path)
          EX_MD:   state_next = S_MD;
          EX_LD:   state_next = S_MRD;
          EX_ST:   state_next = S_ST;
          default: state_next = S_WB;
        endcase
      end
      S_MD:   if (md_done) state_next = S_WB;
      S_LDX:  state_next = S_WB;
      S_WB:   state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 16'd0;
      end_address   <= 16'hFFFF;
      stack_init    <= 16'h8000;
      global_init   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:  start_address <= cfg_data;
        CFG_END:    end_address   <= cfg_data;
        CFG_STACK:  stack_init    <= cfg_data;
        CFG_GLOBAL: global_init   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 16'd0;
      stopped <= 1'b0;
      retired <= 64'd0;
    end else if (accept && s_tuser == OP_RESTART) begin
      pc      <= start_address;
      stopped <= start_address == end_address;
      retired <= 64'd0;
    end else if (accept && s_tuser == OP_STEP && (stopped || pc == end_address)) begin
      stopped <= 1'b1;
    end else if (state == S_WB) begin
      pc      <= r_next;
      stopped <= r_exit || r_next == end_address;
      retired <= retired + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        r_step  <= 1'b0;
        r_instr <= '0;
        r_rd    <= '0;
        r_val   <= '0;
        r_dw    <= 1'b0;
        r_call  <= 1'b0;
        r_code  <= '0;
        r_arg   <= '0;
        r_ill   <= 1'b0;
        r_exit  <= 1'b0;
        iss     <= '0;
        cap_v   <= 1'b0;
        mbytes  <= '0;
        if (s_tuser == OP_LOAD) begin
          mbase <= la_ext[AW-1:0];
          mlen  <= LEN_DOUBLE;
          sdata <= s_tdata[79:16];
          ret   <= S_DONE;
        end else begin
          mbase <= pc_ext[AW-1:0];
          mlen  <= LEN_WORD;
          ret   <= S_DEC;
        end
      end
      S_MRD: begin
        cap_v   <= iss != mlen;
        cap_idx <= iss[2:0];
        if (iss != mlen) iss <= iss + 4'd1;
        if (cap_v) mbytes[{cap_idx, 3'b000} +: 8] <= mem_rdata;
      end
      S_ST: begin
        if (iss != mlen) iss <= iss + 4'd1;
      end
      S_DEC: begin
        insn    <= mbytes[31:0];
        r_instr <= mbytes[31:0];
        r_pc    <= pc;
        r_step  <= 1'b1;
      end
      S_EXE: begin
        r_val   <= ex_val;
        r_wr    <= ex_wr;
        r_w     <= ex_w;
        r_next  <= ex_next;
        r_ill   <= ex_ill;
        r_call  <= ex_call;
        r_code  <= ex_call ? a : '0;
        r_arg   <= ex_call ? b : '0;
        r_exit  <= ex_call && a == EXIT_CODE;
        mbase   <= ea[AW-1:0];
        mlen    <= ex_len;
        sdata   <= b;
        iss     <= '0;
        cap_v   <= 1'b0;
        mbytes  <= '0;
        ret     <= (ex_path == EX_LD) ? S_LDX : S_WB;
      end
      S_MD: begin
        if (md_done) r_val <= r_w ? sext32(md_result) : md_result;
      end
      S_LDX: begin
        unique case (f3)
          F3_LB:   r_val <= {{56{mbytes[7]}}, mbytes[7:0]};
          F3_LH:   r_val <= {{48{mbytes[15]}}, mbytes[15:0]};
          F3_LW:   r_val <= sext32(mbytes);
          default: r_val <= mbytes;
        endcase
      end
      S_WB: begin
        r_dw  <= r_wr && rd != 5'd0;
        r_rd  <= (r_wr && rd != 5'd0) ? rd : 5'd0;
        r_val <= (r_wr && rd != 5'd0) ? r_val : 64'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, r_ill, stopped, r_arg, r_code, r_call, r_dw, r_val, r_rd,
                  r_instr, r_step ? r_pc : pc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/rvc_mem.sv =====
module rvc_mem #(
  parameter int MEM_BYTES = 65536,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rvc_regfile.sv =====
module rvc_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  raddr1,
  input  logic [4:0]  raddr2,
  output logic [63:0] rdata1,
  output logic [63:0] rdata2,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [63:0] wdata
);
  logic [63:0] mem [32];
  logic [31:0] valid;
  logic [63:0] q1, q2;
  logic        v1, v2;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q1 <= mem[raddr1];
    q2 <= mem[raddr2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      v1 <= valid[raddr1];
      v2 <= valid[raddr2];
    end
  end

  assign rdata1 = v1 ? q1 : '0;
  assign rdata2 = v2 ? q2 : '0;
endmodule

// ===== hw/rtl/rvc_muldiv.sv =====
module rvc_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  rvc_pkg::md_req_t req,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [63:0]      result
);
  import rvc_pkg::*;

  md_state_t   st, st_next;
  md_op_t      kind;
  logic [64:0] hi;
  logic [63:0] lo, mb, aorig;
  logic        na, nb, bz;
  logic [5:0]  cnt;
  logic [64:0] msum, rsh;
  logic        ge;
  logic [127:0] prod, sprod;
  logic [63:0]  ma_in, mb_in;

  assign ma_in = a[63] ? 64'd0 - a : a;
  assign mb_in = b[63] ? 64'd0 - b : b;
  assign msum  = {1'b0, hi[63:0]} + (lo[0] ? {1'b0, mb} : 65'd0);
  assign rsh   = {hi[63:0], lo[63]};
  assign ge    = rsh >= {1'b0, mb};
  assign prod  = {hi[63:0], lo};
  assign sprod = (na ^ nb) ? 128'd0 - prod : prod;

  always_comb begin
    st_next = st;
    unique case (st)
      MDS_IDLE: if (req.start) st_next = MDS_RUN;
      MDS_RUN:  if (cnt == 6'd0) st_next = MDS_FIN;
      MDS_FIN:  st_next = MDS_IDLE;
      default:  st_next = MDS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= MDS_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      MDS_IDLE: begin
        if (req.start) begin
          kind  <= req.kind;
          na    <= a[63];
          nb    <= b[63];
          bz    <= b == 64'd0;
          aorig <= a;
          hi    <= '0;
          lo    <= ma_in;
          mb    <= mb_in;
          cnt   <= 6'd63;
        end
      end
      MDS_RUN: begin
        cnt <= cnt - 6'd1;
        if (kind == MD_MUL || kind == MD_MULH) begin
          hi <= {1'b0, msum[64:1]};
          lo <= {msum[0], lo[63:1]};
        end else begin
          hi <= ge ? rsh - {1'b0, mb} : rsh;
          lo <= {lo[62:0], ge};
        end
      end
      default: ;
    endcase
  end

  assign done = st == MDS_FIN;

  always_comb begin
    unique case (kind)
      MD_MUL:  result = sprod[63:0];
      MD_MULH: result = sprod[127:64];
      MD_DIV:  result = bz ? '1 : ((na ^ nb) ? 64'd0 - lo : lo);
      MD_REM:  result = bz ? aorig : (na ? 64'd0 - hi[63:0] : hi[63:0]);
      default: result = '0;
    endcase
  end
endmodule

// ===== hw/rtl/rvc_checker.sv =====
module rvc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [255:0] m_tdata
);
  // result beat holds until taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an unknown opcode writes no register
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[248] && m_tdata[117]))
    else $error("illegal instruction wrote a register");

  // write-back fields are zero unless a register was written
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[117] |-> m_tdata[52:48] == 5'd0 && m_tdata[116:53] == 64'd0)
    else $error("write-back fields set without a write");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[118] |-> m_tdata[182:119] == 64'd0 && m_tdata[246:183] == 64'd0)
    else $error("call fields set without a call");
endmodule

bind rv64im_subset_core rvc_checker u_rvc_checker (.*);

// ===== tb/sv/rv64im_subset_core_tb.sv =====
`timescale 1ns / 1ps

module rv64im_subset_core_tb;
  import rvc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [15:0] pc;
    logic [31:0] word;
    logic [4:0]  rd;
    logic [63:0] val;
    logic        wr;
    logic        call;
    logic [63:0] code;
    logic [63:0] arg;
    logic        halt;
    logic        ill;
  } retire_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;   // load_address, load_data
  logic [1:0]   s_tuser = '0;   // op
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // exec_pc, instr_word, dest_index, dest_value, dest_written, call_seen,
  // call_code, call_arg, halted, illegal
  logic [255:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  rv64im_subset_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow core state
  logic [7:0]  mem_img [0:65535];
  bit          mem_ok [0:65535];
  logic [63:0] xreg [0:31];
  logic [15:0] core_pc;
  bit          core_stopped;
  logic [15:0] start_pc, end_pc, sp_init, gp_init;

  retire_t pending_results [$];
  int errors = 0, beats_seen = 0, n_steps = 0, n_calls = 0, n_halts = 0, n_illegal = 0;
  int rx_hold = 0, rx_gap = 0;
  bit no_idle = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 40) $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] word_ext(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic [63:0] mem_rd(logic [15:0] a, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(mem_img[16'(a + i)]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_wr(logic [15:0] a, logic [63:0] v, int n);
    for (int i = 0; i < n; i++) begin
      mem_img[16'(a + i)] = v[8*i +: 8];
      mem_ok[16'(a + i)] = 1;
    end
  endfunction

  function automatic bit span_ok(logic [15:0] a, int n);
    for (int i = 0; i < n; i++) if (!mem_ok[16'(a + i)]) return 0;
    return 1;
  endfunction

  function automatic logic [63:0] div_signed(logic [63:0] a, logic [63:0] b, bit want_rem);
    logic signed [63:0] sa, sb;
    sa = a;
    sb = b;
    if (b == 0) return want_rem ? a : '1;
    if (a == 64'h8000_0000_0000_0000 && b == '1) return want_rem ? 64'd0 : a;
    return want_rem ? 64'(sa % sb) : 64'(sa / sb);
  endfunction

  task automatic execute_item(input logic [1:0] op, input logic [15:0] addr,
                              input logic [63:0] data, output retire_t r);
    logic [31:0]  inst;
    logic [6:0]   opc, f7;
    logic [4:0]   rd, rs1, rs2;
    logic [2:0]   f3;
    logic [9:0]   key;
    logic [5:0]   sh;
    logic [63:0]  a, b, immi, val, t, off, ld;
    logic [127:0] p;
    logic [15:0]  nxt;
    bit           wr;
    r = '{default: '0};
    if (op == OP_RESTART) begin
      core_pc = start_pc;
      xreg[REG_SP] = 64'(sp_init);
      xreg[REG_GP] = 64'(gp_init);
      core_stopped = (core_pc == end_pc);
    end else if (op == OP_LOAD) begin
      mem_wr(addr, data, 8);
    end
    if (op != OP_STEP || core_stopped || core_pc == end_pc) begin
      if (op == OP_STEP) core_stopped = 1;
      r.pc = core_pc;
      r.halt = core_stopped;
      if (r.halt) n_halts++;
      return;
    end
    n_steps++;
    inst = mem_rd(core_pc, 4);
    nxt = core_pc + 16'd4;
    opc = inst[6:0];
    rd = inst[11:7];
    f3 = inst[14:12];
    rs1 = inst[19:15];
    rs2 = inst[24:20];
    f7 = inst[31:25];
    key = {f7, f3};
    a = xreg[rs1];
    b = xreg[rs2];
    immi = {{52{inst[31]}}, inst[31:20]};
    val = '0;
    wr = 0;
    r.pc = core_pc;
    r.word = inst;
    case (opc)
      OPC_OP: begin
        sh = b[5:0];
        wr = 1;
        case (key)
          FK_ADD:  val = a + b;
          FK_SUB:  val = a - b;
          FK_MUL:  val = a * b;
          FK_SLL:  val = a << sh;
          FK_MULH: begin
            p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
            val = p[127:64];
          end
          FK_SLT:  val = 64'($signed(a) < $signed(b));
          FK_XOR:  val = a ^ b;
          FK_DIV:  val = div_signed(a, b, 0);
          FK_SRL:  val = a >> sh;
          FK_SRA:  val = $signed(a) >>> sh;
          FK_OR:   val = a | b;
          FK_REM:  val = div_signed(a, b, 1);
          FK_AND:  val = a & b;
          default: wr = 0;
        endcase
      end
      OPC_OPW: begin
        wr = 1;
        case (key)
          FK_ADD:  val = word_ext(a + b);
          FK_SUB:  val = word_ext(a - b);
          FK_MUL:  val = word_ext(a * b);
          FK_DIV:  val = word_ext(div_signed(word_ext(a), word_ext(b), 0));
          FK_REM:  val = word_ext(div_signed(word_ext(a), word_ext(b), 1));
          default: wr = 0;
        endcase
      end
      OPC_LOAD: begin
        t = a + immi;
        wr = 1;
        case (f3)
          F3_LB: begin
            ld = mem_rd(t[15:0], 1);
            val = {{56{ld[7]}}, ld[7:0]};
          end
          F3_LH: begin
            ld = mem_rd(t[15:0], 2);
            val = {{48{ld[15]}}, ld[15:0]};
          end
          F3_LW:   val = word_ext(mem_rd(t[15:0], 4));
          F3_LD:   val = mem_rd(t[15:0], 8);
          default: wr = 0;
        endcase
      end
      OPC_OPIMM: begin
        sh = inst[25:20];
        wr = 1;
        if (f3 == F3_ADDI) val = a + immi;
        else if (f3 == F3_SLLI && inst[31:26] == F6_SRL) val = a << sh;
        else if (f3 == F3_SLTI) val = 64'($signed(a) < $signed(immi));
        else if (f3 == F3_XORI) val = a ^ immi;
        else if (f3 == F3_SRI && inst[31:26] == F6_SRL) val = a >> sh;
        else if (f3 == F3_SRI && inst[31:26] == F6_SRA) val = $signed(a) >>> sh;
        else if (f3 == F3_ORI) val = a | immi;
        else if (f3 == F3_ANDI) val = a & immi;
        else wr = 0;
      end
      OPC_OPIMMW: if (f3 == F3_ADDI) begin
        val = word_ext(a + immi);
        wr = 1;
      end
      OPC_JALR: if (f3 == 3'd0) begin
        t = (a + immi) & ~64'd1;
        val = 64'(nxt);
        wr = 1;
        nxt = t[15:0];
      end
      OPC_SYSTEM: if (f3 == 3'd0 && inst[31:20] == 12'd0) begin
        r.call = 1;
        r.code = xreg[REG_A7];
        r.arg = xreg[REG_A0];
        n_calls++;
        if (xreg[REG_A7] == EXIT_CODE) core_stopped = 1;
      end
      OPC_STORE: begin
        t = a + {{52{inst[31]}}, inst[31:25], inst[11:7]};
        if (f3 <= 3'd3) mem_wr(t[15:0], b, 1 << f3);
      end
      OPC_BRANCH: begin
        off = {{51{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b) ||
            (f3 == F3_BLT && $signed(a) < $signed(b)) ||
            (f3 == F3_BGE && $signed(a) >= $signed(b)))
          nxt = core_pc + off[15:0];
      end
      OPC_AUIPC: begin
        val = 64'(core_pc) + word_ext({inst[31:12], 12'd0});
        wr = 1;
      end
      OPC_LUI: begin
        val = word_ext({inst[31:12], 12'd0});
        wr = 1;
      end
      OPC_JAL: begin
        off = {{43{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        val = 64'(nxt);
        wr = 1;
        nxt = core_pc + off[15:0];
      end
      default: begin
        r.ill = 1;
        n_illegal++;
      end
    endcase
    if (wr && rd != 5'd0) begin
      xreg[rd] = val;
      r.rd = rd;
      r.val = val;
      r.wr = 1;
    end
    core_pc = nxt;
    if (core_pc == end_pc) core_stopped = 1;
    r.halt = core_stopped;
    if (r.halt) n_halts++;
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] gen_instr();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [9:0]  key;
    logic [11:0] imm;
    logic [12:0] boff;
    logic [20:0] joff;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom);
    imm = $urandom_range(0, 1) ? 12'($urandom_range(0, 31)) - 12'd16 : 12'($urandom);
    boff = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 63)) - 13'd32;
    joff = ($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'($urandom_range(0, 127)) - 21'd64;
    case ($urandom_range(0, 15))
      0: begin
        case ($urandom_range(0, 13))
          0: key = FK_ADD;   1: key = FK_SUB;  2: key = FK_MUL;  3: key = FK_SLL;
          4: key = FK_MULH;  5: key = FK_SLT;  6: key = FK_XOR;  7: key = FK_DIV;
          8: key = FK_SRL;   9: key = FK_SRA; 10: key = FK_OR;  11: key = FK_REM;
          12: key = FK_AND;
          default: key = 10'($urandom);
        endcase
        return {key[9:3], rs2, rs1, key[2:0], rd, OPC_OP};
      end
      1: begin
        case ($urandom_range(0, 5))
          0: key = FK_ADD;  1: key = FK_SUB;  2: key = FK_MUL;
          3: key = FK_DIV;  4: key = FK_REM;
          default: key = 10'($urandom);
        endcase
        return {key[9:3], rs2, rs1, key[2:0], rd, OPC_OPW};
      end
      2: return {imm, rs1, 3'($urandom_range(0, 4)), rd, OPC_LOAD};
      3: begin
        if (f3 == F3_SLLI || f3 == F3_SRI)
          imm = {($urandom_range(0, 3) == 0) ? 6'($urandom) :
                 (f3 == F3_SRI && $urandom_range(0, 1)) ? F6_SRA : F6_SRL, 6'($urandom)};
        return {imm, rs1, f3, rd, OPC_OPIMM};
      end
      4: return {imm, rs1, F3_ADDI, rd, OPC_OPIMM};
      5: return {imm, rs1, ($urandom_range(0, 5) == 0) ? f3 : 3'd0, rd, OPC_OPIMMW};
      6: return {imm, rs1, ($urandom_range(0, 5) == 0) ? f3 : 3'd0, rd, OPC_JALR};
      7: begin
        case ($urandom_range(0, 3))
          0: return {12'd4, 5'd0, F3_ADDI, REG_A7, OPC_OPIMM};
          1: return {imm, 5'd0, F3_ADDI, REG_A7, OPC_OPIMM};
          2: return {25'd0, OPC_SYSTEM};
          default: return {12'($urandom_range(0, 1)), rs1, 3'($urandom_range(0, 1)), rd,
                           OPC_SYSTEM};
        endcase
      end
      8: return {imm[11:5], rs2, rs1, 3'($urandom_range(0, 4)), imm[4:0], OPC_STORE};
      9: return {boff[12], boff[10:5], rs2, rs1, f3, boff[4:1], boff[11], OPC_BRANCH};
      10: return {20'($urandom), rd, OPC_AUIPC};
      11: return {20'($urandom), rd, OPC_LUI};
      12: return {joff[20], joff[10:1], joff[11], joff[19:12], rd, OPC_JAL};
      13: return $urandom;
      default: return {imm, rs1, F3_ADDI, rd, OPC_OPIMM};
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [63:0] data);
    retire_t r;
    int gap;
    execute_item(op, addr, data, r);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {data, addr};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] st, logic [15:0] en, logic [15:0] sp, logic [15:0] gp);
    logic [15:0] vals [4];
    vals = '{st, en, sp, gp};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    start_pc = st;
    end_pc = en;
    sp_init = sp;
    gp_init = gp;
  endtask

  task automatic load_code(logic [15:0] a, bit safe);
    logic [31:0] w0, w1;
    w0 = safe ? {12'd1, 5'd1, F3_ADDI, 5'd1, OPC_OPIMM} : gen_instr();
    w1 = safe ? w0 : gen_instr();
    send_item(OP_LOAD, a, {w1, w0});
  endtask

  // keep fetch and data reads on bytes that hold known contents
  task automatic step_core();
    logic [31:0] inst;
    logic [63:0] t;
    int n;
    bit ready;
    ready = core_stopped || core_pc == end_pc;
    for (int k = 0; k < 3 && !ready; k++) begin
      if (!span_ok(core_pc, 4)) begin
        load_code(core_pc, 0);
      end else begin
        inst = mem_rd(core_pc, 4);
        t = xreg[inst[19:15]] + {{52{inst[31]}}, inst[31:20]};
        n = (inst[6:0] == OPC_LOAD && inst[14:12] <= F3_LD) ? (1 << inst[14:12]) : 0;
        if (n > 0 && !span_ok(t[15:0], n)) send_item(OP_LOAD, t[15:0], {$urandom, $urandom});
        else ready = 1;
      end
    end
    if (!ready) load_code(core_pc, 1);
    send_item(OP_STEP, 16'($urandom), {$urandom, $urandom});
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if ((core_stopped && r < 50) || r < 3) send_item(OP_RESTART, 16'($urandom), {$urandom, $urandom});
    else if (r < 10) send_item(OP_LOAD, 16'($urandom), {$urandom, $urandom});
    else if (r < 12) send_item(OP_NONE, 16'($urandom), {$urandom, $urandom});
    else step_core();
  endtask

  task automatic test_directed();
    logic [31:0] prog [10];
    set_config(16'h0000, 16'hFFFF, 16'h8000, 16'h0000);
    prog = '{
      {12'hFFF, 5'd0, F3_ADDI, 5'd6, OPC_OPIMM},
      {6'd0, 6'd63, 5'd6, F3_SLLI, 5'd5, OPC_OPIMM},
      {FK_DIV[9:3], 5'd6, 5'd5, FK_DIV[2:0], 5'd7, OPC_OP},
      {FK_REM[9:3], 5'd6, 5'd5, FK_REM[2:0], 5'd8, OPC_OP},
      {FK_DIV[9:3], 5'd0, 5'd5, FK_DIV[2:0], 5'd9, OPC_OP},
      {FK_REM[9:3], 5'd0, 5'd6, FK_REM[2:0], 5'd10, OPC_OPW},
      {FK_MULH[9:3], 5'd6, 5'd5, FK_MULH[2:0], 5'd11, OPC_OP},
      32'h0000_007F,
      {12'd4, 5'd0, F3_ADDI, REG_A7, OPC_OPIMM},
      {25'd0, OPC_SYSTEM}};
    for (int i = 0; i < 5; i++) send_item(OP_LOAD, 16'(8 * i), {prog[2*i+1], prog[2*i]});
    send_item(OP_RESTART, 16'h0, 64'h0);
    repeat (11) send_item(OP_STEP, 16'h0, 64'h0);
    send_item(OP_NONE, 16'hFFFF, '1);
    send_item(OP_LOAD, 16'hFFFF, '1);
    send_item(OP_LOAD, 16'h1000, '0);
    send_item(OP_RESTART, 16'h0, 64'h0);
    send_item(OP_STEP, 16'h0, 64'h0);
    // restart straight onto the halt address
    set_config(16'h0100, 16'h0100, 16'hFFFF, 16'hFFFF);
    send_item(OP_RESTART, 16'h0, 64'h0);
    send_item(OP_STEP, 16'h0, 64'h0);
  endtask

  task automatic test_random_programs();
    logic [15:0] st;
    for (int ph = 0; ph < 7; ph++) begin
      st = 16'($urandom);
      case (ph)
        0: set_config(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        1: set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        2, 3: set_config(st, st + 16'(4 * $urandom_range(3, 40)), 16'($urandom), 16'($urandom));
        default: set_config(st, 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      send_item(OP_RESTART, 16'h0, 64'h0);
      repeat (210) random_item();
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 400;
    repeat (12) random_item();
    drain();
    repeat (12) random_item();
  endtask

  task automatic test_no_idle();
    drain();
    no_idle = 1;
    repeat (150) random_item();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        retire_t want;
        beats_seen++;
        if (pending_results.size() == 0) begin
          report("beat with nothing pending", m_tdata[63:0], 64'h0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[15:0] != want.pc) report("exec_pc", m_tdata[15:0], want.pc);
          if (m_tdata[47:16] != want.word) report("instr_word", m_tdata[47:16], want.word);
          if (m_tdata[52:48] != want.rd) report("dest_index", m_tdata[52:48], want.rd);
          if (m_tdata[116:53] != want.val) report("dest_value", m_tdata[116:53], want.val);
          if (m_tdata[117] != want.wr) report("dest_written", m_tdata[117], want.wr);
          if (m_tdata[118] != want.call) report("call_seen", m_tdata[118], want.call);
          if (m_tdata[182:119] != want.code) report("call_code", m_tdata[182:119], want.code);
          if (m_tdata[246:183] != want.arg) report("call_arg", m_tdata[246:183], want.arg);
          if (m_tdata[247] != want.halt) report("halted", m_tdata[247], want.halt);
          if (m_tdata[248] != want.ill) report("illegal", m_tdata[248], want.ill);
        end
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        rx_gap = $urandom_range(1, 14) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) xreg[i] = '0;
    core_pc = '0;
    core_stopped = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_programs();
    test_backpressure();
    test_no_idle();
    drain();
    $display("%0d beats checked: %0d instructions, %0d ecalls, %0d illegal, %0d halted",
             beats_seen, n_steps, n_calls, n_illegal, n_halts);
    $display("covered preload, restart, halt and exit paths under random stalls and config");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rvc_pkg.sv
hw/rtl/rvc_mem.sv
hw/rtl/rvc_regfile.sv
hw/rtl/rvc_muldiv.sv
hw/rtl/rv64im_subset_core.sv
hw/rtl/rvc_checker.sv
tb/sv/rv64im_subset_core_tb.sv
